// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // default store depth
  localparam int CAPACITY_DEF = 16;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
    logic               is_empty;
  } spq_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_DONE
  } spq_state_t;

endpackage

`default_nettype wire

// ===== src/spq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered queue of signed 32-bit keys held as a circular list in one
// CAPACITY-deep RAM (one write and one registered read port). Command 0 appends
// at the tail, command 1 places the key before the first stored entry that is
// not smaller (newest first among equal keys), command 2 removes the head.
// Every input beat yields one output beat with the removed key (zero for other
// commands), a status (done, remove from empty, append or insert dropped because
// full), the occupancy and an empty flag. Append, dropped and unused commands
// go from idle straight to the done state, a remove passes through the pop
// state, and an ordered insert walks the list once, one entry per cycle through
// the RAM ports, before it reaches the done state. The done state loads the
// output register once that register is free, so a stalled output register
// holds the item there. One item is in work at a time; the next input beat is
// taken as soon as the result sits in the output register, even while that
// register is stalled.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire spq_pkg::spq_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output spq_pkg::spq_out_t     out_data
);

  import spq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  spq_state_t state_r, state_nxt;

  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               placed_r, placed_nxt;
  logic [31:0]        carry_r, carry_nxt;
  logic signed [31:0] key_r, key_nxt;
  spq_out_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  spq_out_t           out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic in_fire;
  logic out_free;
  logic is_full;
  logic is_zero;

  // logical list position to ram address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(head) + {1'b0, off};
    if (s >= CAP_W) begin
      s = s - CAP_W;
    end
    return s[AW-1:0];
  endfunction

  // result beat from key, status and new count
  function automatic spq_out_t mk_res(input logic [31:0] hv,
                                      input logic [1:0]  st,
                                      input logic [CW-1:0] cnt);
    spq_out_t    r;
    logic [CW+4:0] e;
    e            = (CW + 5)'(cnt);
    r.head_value = hv;
    r.status     = st;
    r.occupancy  = e[4:0];
    r.is_empty   = (cnt == '0);
    return r;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_full   = (count_r == CAP_C);
  assign is_zero   = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  spq_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.command == CMD_INSERT && !is_full) begin
            state_nxt = S_SCAN;
          end else if (in_data.command == CMD_REMOVE && !is_zero) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == count_r) begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    placed_nxt    = placed_r;
    carry_nxt     = carry_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = phys(head_r, idx_r);
    ram_wdata     = carry_r;
    ram_raddr     = head_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.command)
            CMD_APPEND: begin
              if (is_full) begin
                res_nxt = mk_res('0, STAT_FULL, count_r);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_r, count_r);
                ram_wdata = in_data.value;
                count_nxt = count_r + 1'b1;
                res_nxt   = mk_res('0, STAT_DONE, count_r + 1'b1);
              end
            end
            CMD_INSERT: begin
              if (is_full) begin
                res_nxt = mk_res('0, STAT_FULL, count_r);
              end else begin
                key_nxt    = in_data.value;
                idx_nxt    = '0;
                placed_nxt = 1'b0;
              end
            end
            CMD_REMOVE: begin
              if (is_zero) begin
                res_nxt = mk_res('0, STAT_EMPTY, count_r);
              end else begin
                head_nxt  = (head_r == LAST_A) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
              res_nxt = mk_res('0, STAT_DONE, count_r);
            end
          endcase
        end
      end
      S_SCAN: begin
        // one entry per cycle: read next, write shifted current
        ram_raddr = phys(head_r, idx_r + 1'b1);
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == count_r) begin
          ram_we    = 1'b1;
          ram_wdata = placed_r ? carry_r : key_r;
          count_nxt = count_r + 1'b1;
          res_nxt   = mk_res('0, STAT_DONE, count_r + 1'b1);
        end else if (placed_r) begin
          ram_we    = 1'b1;
          ram_wdata = carry_r;
          carry_nxt = ram_rdata;
        end else if ($signed(ram_rdata) >= key_r) begin
          ram_we     = 1'b1;
          ram_wdata  = key_r;
          carry_nxt  = ram_rdata;
          placed_nxt = 1'b1;
        end
      end
      S_POP: begin
        res_nxt = mk_res(ram_rdata, STAT_DONE, count_r);
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    placed_r   <= placed_nxt;
    carry_r    <= carry_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= count_r)
    else $error("insert walk past the tail");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_SCAN))
    else $error("ram write outside append or insert walk");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output beat not from a finished item");
`endif

endmodule

`default_nettype wire
